// ===== rtl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and helpers for the Playfair digraph cipher block.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int SIDE     = 5;
   localparam int CELLS    = SIDE * SIDE;
   localparam int LETTER_W = 8;
   localparam int IDX_W    = 5;
   localparam int POS_W    = 3;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [POS_W-1:0]    pos_type;

   // Request command codes
   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_XFORM = 1'b1
   } cmd_type;

   // Direction register codes
   typedef enum logic {
      DIR_ENC = 1'b0,
      DIR_DEC = 1'b1
   } dir_type;

   typedef struct packed {
      logic             cmd;
      logic [IDX_W-1:0] cell_index;
      letter_type       cell_letter;
      letter_type       first_letter;
      letter_type       second_letter;
   } req_type;

   typedef struct packed {
      letter_type first_out;
      letter_type second_out;
      logic       not_found;
   } rsp_type;

   // One key-square row, column 0 at index 0
   typedef letter_type [SIDE-1:0] row_type;
   typedef row_type    [SIDE-1:0] square_type;

   // What one row lane found for both letters
   typedef struct packed {
      logic    hit_a;
      pos_type col_a;
      logic    hit_b;
      pos_type col_b;
   } lane_hit_type;

   typedef lane_hit_type [SIDE-1:0] lane_hits_type;

   // Step a row or column position by one with wrap
   function automatic pos_type shift_pos(input pos_type p, input logic back);
      pos_type r;
      if (back) begin
         r = (p == '0) ? pos_type'(SIDE - 1) : pos_type'(p - pos_type'(1));
      end else begin
         r = (p == pos_type'(SIDE - 1)) ? '0 : pos_type'(p + pos_type'(1));
      end
      return r;
   endfunction

endpackage

// ===== rtl/pfc_row_lane.sv =====
// ----------------------------------------------------------------------------
// pfc_row_lane
// Compares both letters against the cells of one key-square row and reports
// the lowest matching column for each.
// ----------------------------------------------------------------------------
module pfc_row_lane (
   input  pfc_pkg::row_type      row_cells,
   input  pfc_pkg::letter_type   letter_a,
   input  pfc_pkg::letter_type   letter_b,
   output pfc_pkg::lane_hit_type hit
);
   import pfc_pkg::*;

   // Scan from the top so the lowest matching column wins
   always_comb begin
      hit = '0;
      for (int c = SIDE - 1; c >= 0; c--) begin
         if (row_cells[c] == letter_a) begin
            hit.hit_a = 1'b1;
            hit.col_a = pos_type'(c);
         end
         if (row_cells[c] == letter_b) begin
            hit.hit_b = 1'b1;
            hit.col_b = pos_type'(c);
         end
      end
   end

endmodule

// ===== rtl/pfc_merge.sv =====
// ----------------------------------------------------------------------------
// pfc_merge
// Combines the row lane results: picks the first matching row for each
// letter and applies the row, column or rectangle rule.
// ----------------------------------------------------------------------------
module pfc_merge (
   input  pfc_pkg::lane_hits_type hits,
   input  pfc_pkg::square_type    square,
   input  logic                   back,
   output pfc_pkg::rsp_type       result
);
   import pfc_pkg::*;

   logic    fa, fb;
   pos_type ra, ca, rb, cb;

   // Pick lowest row holding each letter
   always_comb begin
      fa = 1'b0;
      fb = 1'b0;
      ra = '0;
      ca = '0;
      rb = '0;
      cb = '0;
      for (int r = SIDE - 1; r >= 0; r--) begin
         if (hits[r].hit_a) begin
            fa = 1'b1;
            ra = pos_type'(r);
            ca = hits[r].col_a;
         end
         if (hits[r].hit_b) begin
            fb = 1'b1;
            rb = pos_type'(r);
            cb = hits[r].col_b;
         end
      end
   end

   // Apply the digraph rule
   always_comb begin
      result = '0;
      if (!fa || !fb) begin
         result.not_found = 1'b1;
      end else if (ra == rb) begin
         result.first_out  = square[ra][shift_pos(ca, back)];
         result.second_out = square[rb][shift_pos(cb, back)];
      end else if (ca == cb) begin
         result.first_out  = square[shift_pos(ra, back)][ca];
         result.second_out = square[shift_pos(rb, back)][cb];
      end else begin
         result.first_out  = square[ra][cb];
         result.second_out = square[rb][ca];
      end
   end

endmodule

// ===== rtl/playfair_digraph_cipher.sv =====
// A transform request shows its response in the cycle after acceptance.
// Throughput: one request per cycle unless a waiting response is stalled; loads and transforms may follow back to back.
// The rate is set by the combinational row-lane compare and merge into the output register.
// Loads give no response; a load is seen by a transform accepted the next cycle.
// Reset (synchronous): key square cleared to zero, direction set to encrypt,
// output register emptied.
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair digraph substitution over a 5x5 key square held in flops, with
// one compare lane per row and a merging stage feeding the response register.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pfc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pfc_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);
   import pfc_pkg::*;

   square_type    square_ff, square_in;
   logic          dir_ff, dir_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   lane_hits_type hits;
   rsp_type       result;
   logic          req_accept;

   // Hold requests only while a response is waiting and stalled
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // One compare lane per row
   for (genvar r = 0; r < SIDE; r++) begin : g_lane
      pfc_row_lane u_lane (
         .row_cells (square_ff[r]),
         .letter_a  (req_payload.first_letter),
         .letter_b  (req_payload.second_letter),
         .hit       (hits[r])
      );
   end

   pfc_merge u_merge (
      .hits   (hits),
      .square (square_ff),
      .back   (dir_ff == DIR_DEC),
      .result (result)
   );

   // Write the addressed cell on a load; out-of-range indexes match nothing
   always_comb begin
      square_in = square_ff;
      if (req_accept && req_payload.cmd == CMD_LOAD) begin
         for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
               if (req_payload.cell_index == IDX_W'(r * SIDE + c)) begin
                  square_in[r][c] = req_payload.cell_letter;
               end
            end
         end
      end
   end

   // Direction register
   assign dir_in = (csr_valid && csr_ready) ? csr_data : dir_ff;

   // Advance or drop the response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (req_accept && req_payload.cmd == CMD_XFORM) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff    <= '0;
         dir_ff       <= DIR_ENC;
         rsp_valid_ff <= 1'b0;
      end else begin
         square_ff    <= square_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/pfc_checker.sv =====
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks for the Playfair digraph cipher, bound to the top level.
// ----------------------------------------------------------------------------
module pfc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input pfc_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pfc_pkg::rsp_type rsp_payload
);
   import pfc_pkg::*;

   // A stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // An accepted transform request gives a response next cycle
   a_xform_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.cmd == CMD_XFORM |=> rsp_valid)
      else $error("transform request gave no response");

   // A load gives no response
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.cmd == CMD_LOAD
      && !(rsp_valid && rsp_stall) |=> !rsp_valid)
      else $error("load request gave a response");

   // A missing letter yields zero letters
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.not_found |->
      rsp_payload.first_out == '0 && rsp_payload.second_out == '0)
      else $error("not_found response carries letters");

   // Reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
